[design/adam_optimizer_update_assert.svh]
// assertion macros for the adam optimizer update block
`ifndef ADAM_OPTIMIZER_UPDATE_ASSERT_SVH
`define ADAM_OPTIMIZER_UPDATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ADAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ADAM_ASSERT_NEVER(lbl, expr, msg) \
  `ADAM_ASSERT(lbl, !(expr), msg)
`else
`define ADAM_ASSERT(lbl, prop, msg)
`define ADAM_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[design/adam_pkg.sv]
// shared types, constants and step functions of the adam optimizer update block
package adam_pkg;

  localparam int NUM_PARAMS = 4096;
  localparam int ADDR_W     = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam int PIDX_W     = 12;
  localparam int DATA_W     = 32;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [23:0] LR_RST    = 24'd16777;
  localparam logic [15:0] B1_RST    = 16'd58982;
  localparam logic [15:0] B2_RST    = 16'd65470;
  localparam logic [7:0]  GUARD_RST = 8'd1;
  localparam logic [16:0] POW_ONE   = 17'd65536;

  // pipeline stage plan after the moment update
  localparam int SV_STEPS   = 28;
  localparam int SR_STEPS   = 17;
  localparam int ADIV_FIRST = SR_STEPS + 1;
  localparam int ADIV_BITS  = 32;
  localparam int MUL_STG    = ADIV_FIRST + ADIV_BITS;
  localparam int DSAT_STG   = MUL_STG + 1;
  localparam int DDIV_FIRST = DSAT_STG + 1;
  localparam int DDIV_BITS  = 34;
  localparam int NSTG       = DDIV_FIRST + DDIV_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE   = 2'd0,
    REG_FIRST_DECAY  = 2'd1,
    REG_SECOND_DECAY = 2'd2,
    REG_DENOM_GUARD  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [23:0] learn_rate;
    logic [15:0] first_decay;
    logic [15:0] second_decay;
    logic [7:0]  denom_guard;
  } cfg_t;

  typedef struct packed {
    logic [PIDX_W-1:0] idx;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] grad;
    logic [16:0]       d1;
    logic [16:0]       d2;
  } item_t;

  typedef struct packed {
    logic              valid;
    item_t             item;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] v;
  } moment_t;

  typedef struct packed {
    logic [57:0] x;
    logic [57:0] r;
  } sq_t;

  typedef struct packed {
    logic [29:0] rem;
    logic        qbit;
  } div_t;

  typedef struct packed {
    logic        fault;
    logic [31:0] weight;
    logic        mneg;
    logic [31:0] mabs;
    logic [16:0] d1;
    sq_t         sv;
    sq_t         sr;
    logic        asat;
    logic [29:0] arem;
    logic [31:0] anum;
    logic [31:0] aq;
    logic [28:0] den;
    logic [63:0] mag;
    logic        dsat;
    logic [29:0] drem;
    logic [33:0] q;
  } core_t;

  // one digit of the integer square root
  function automatic sq_t sq_step(sq_t s, logic [57:0] b);
    logic [58:0] t;
    sq_t n;
    t = {1'b0, s.r} + {1'b0, b};
    if ({1'b0, s.x} >= t) begin
      n.x = s.x - t[57:0];
      n.r = (s.r >> 1) + b;
    end else begin
      n.x = s.x;
      n.r = s.r >> 1;
    end
    return n;
  endfunction

  // one quotient bit of restoring division
  function automatic div_t div_step(logic [29:0] rem, logic b, logic [28:0] d);
    logic [30:0] t;
    div_t n;
    t = {rem, b};
    if (t >= {2'b00, d}) begin
      n.rem  = 30'(t - {2'b00, d});
      n.qbit = 1'b1;
    end else begin
      n.rem  = t[29:0];
      n.qbit = 1'b0;
    end
    return n;
  endfunction

endpackage

[design/adam_if.sv]
// request and result channel interfaces of the adam optimizer update block
interface adam_in_if import adam_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     new_step;
  logic [PIDX_W-1:0]        param_index;
  logic signed [DATA_W-1:0] weight_in;
  logic signed [DATA_W-1:0] gradient;
  modport source (output valid, new_step, param_index, weight_in, gradient, input ready);
  modport sink (input valid, new_step, param_index, weight_in, gradient, output ready);
endinterface

interface adam_out_if import adam_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] weight_out;
  logic                     bias_fault;
  modport source (output valid, weight_out, bias_fault, input ready);
  modport sink (input valid, weight_out, bias_fault, output ready);
endinterface

[design/adam_optimizer_update.sv]
// top level of the adam optimizer update block
// usage:
//   requests enter on in_if (new_step, param_index, weight_in, gradient) and are
//   accepted when valid and ready are both high; results leave on out_if
//   (weight_out, bias_fault) under the same valid/ready rule.
//   configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while idle.
//   one request per cycle is taken unless an output stall or the clear pass
//   holds ready low; results pass the digit-per-stage root and division stages.
//   moments live in two single-port-write memories read on the accept edge;
//   back-to-back requests to the same index see the prior update by forwarding.
//   after reset both moment memories are cleared, one entry per cycle, over all
//   4096 entries; ready stays low during that pass. decay powers restart at 1.0.
//   when out_if.ready is low the pipeline keeps moving until its last stage
//   holds a result behind the waiting output register, then it stops as a
//   whole and in_if.ready drops.
`include "adam_optimizer_update_assert.svh"
module adam_optimizer_update import adam_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  adam_in_if.sink               in_if,
  adam_out_if.source            out_if
);

  cfg_t        cfg_q;
  logic [16:0] p1_q, p2_q, p1_use, p2_use;
  logic [32:0] adv1, adv2;
  logic        en, accept, clr_busy;
  item_t       item;
  moment_t     mo;
  core_t       seed;
  core_t       stg_q [1:NSTG];
  logic        vld_q [1:NSTG];
  logic        out_valid_q;
  logic [31:0] out_w_q, res_w;
  logic        out_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_rate   <= LR_RST;
      cfg_q.first_decay  <= B1_RST;
      cfg_q.second_decay <= B2_RST;
      cfg_q.denom_guard  <= GUARD_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LEARN_RATE:   cfg_q.learn_rate   <= cfg_data_i[23:0];
        REG_FIRST_DECAY:  cfg_q.first_decay  <= cfg_data_i[15:0];
        REG_SECOND_DECAY: cfg_q.second_decay <= cfg_data_i[15:0];
        REG_DENOM_GUARD:  cfg_q.denom_guard  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign en           = !(vld_q[NSTG] && out_valid_q && !out_if.ready);
  assign in_if.ready  = en && !clr_busy;
  assign accept       = in_if.valid && in_if.ready;

  // decay powers advance on the first request of a step
  always_comb begin
    adv1   = 33'(p1_q) * 33'(cfg_q.first_decay);
    adv2   = 33'(p2_q) * 33'(cfg_q.second_decay);
    p1_use = in_if.new_step ? adv1[32:16] : p1_q;
    p2_use = in_if.new_step ? adv2[32:16] : p2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= POW_ONE;
      p2_q <= POW_ONE;
    end else if (accept) begin
      p1_q <= p1_use;
      p2_q <= p2_use;
    end
  end

  always_comb begin
    item.idx    = in_if.param_index;
    item.weight = in_if.weight_in;
    item.grad   = in_if.gradient;
    item.d1     = POW_ONE - p1_use;
    item.d2     = POW_ONE - p2_use;
  end

  adam_moment_unit u_moment (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .accept_i   (accept),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .clr_busy_o (clr_busy),
    .mo_o       (mo)
  );

  always_comb begin
    seed        = '0;
    seed.fault  = (mo.item.d1 == '0);
    seed.weight = mo.item.weight;
    seed.mneg   = mo.m[31];
    seed.mabs   = mo.m[31] ? 32'(-signed'(mo.m)) : mo.m;
    seed.d1     = mo.item.d1;
    seed.sv.x   = {2'b00, mo.v, 24'b0};
    seed.sr.x   = 58'({mo.item.d2, 16'b0});
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int SV_SH = (k < SV_STEPS) ? 2 * (SV_STEPS - 1 - k) : 0;
    localparam int SR_SH = (k < SR_STEPS) ? 2 * (SR_STEPS - 1 - k) : 0;
    localparam bit IN_A  = (k >= ADIV_FIRST) && (k < ADIV_FIRST + ADIV_BITS);
    localparam bit IN_D  = (k >= DDIV_FIRST) && (k < DDIV_FIRST + DDIV_BITS);
    localparam int AB    = IN_A ? ADIV_BITS - 1 - (k - ADIV_FIRST) : 0;
    localparam int DB    = IN_D ? DDIV_BITS - 1 - (k - DDIV_FIRST) : 0;
    core_t cur, nxt;
    logic  cur_vld;

    if (k == 0) begin : g_first
      assign cur     = seed;
      assign cur_vld = mo.valid;
    end else begin : g_rest
      assign cur     = stg_q[k];
      assign cur_vld = vld_q[k];
    end

    always_comb begin
      logic [40:0] num;
      logic [31:0] alpha;
      logic [28:0] den;
      div_t        dv;
      num   = '0;
      alpha = '0;
      den   = '0;
      dv    = '0;
      nxt   = cur;
      if (k < SV_STEPS) begin
        nxt.sv = sq_step(cur.sv, 58'(1) << SV_SH);
      end
      if (k < SR_STEPS) begin
        nxt.sr = sq_step(cur.sr, 58'(1) << SR_SH);
      end
      if (k == SR_STEPS) begin
        num      = 41'(cfg_q.learn_rate) * 41'(cur.sr.r[16:0]);
        nxt.asat = 17'(num[40:32]) >= cur.d1;
        nxt.arem = 30'(num[40:32]);
        nxt.anum = num[31:0];
      end
      if (IN_A) begin
        dv       = div_step(cur.arem, cur.anum[AB], 29'(cur.d1));
        nxt.arem = dv.rem;
        nxt.aq   = {cur.aq[30:0], dv.qbit};
      end
      if (k == SV_STEPS) begin
        den     = 29'(cur.sv.r[27:0]) + 29'(cfg_q.denom_guard);
        nxt.den = (den == '0) ? 29'd1 : den;
      end
      if (k == MUL_STG) begin
        alpha   = cur.asat ? 32'hFFFF_FFFF : cur.aq;
        nxt.mag = 64'(alpha) * 64'(cur.mabs);
      end
      if (k == DSAT_STG) begin
        nxt.dsat = cur.mag[63:34] >= 30'(cur.den);
        nxt.drem = cur.mag[63:34];
      end
      if (IN_D) begin
        dv       = div_step(cur.drem, cur.mag[DB], cur.den);
        nxt.drem = dv.rem;
        nxt.q    = {cur.q[32:0], dv.qbit};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[k+1] <= nxt;
      end
    end
  end

  // final step: clamp quotient, apply sign, saturate; a fault passes the weight unchanged
  always_comb begin
    logic [33:0]        q;
    logic signed [35:0] w36, qd, r36;
    q   = (stg_q[NSTG].dsat || stg_q[NSTG].q > 34'h2_0000_0000) ?
          34'h2_0000_0000 : stg_q[NSTG].q;
    w36 = 36'(signed'(stg_q[NSTG].weight));
    qd  = $signed({2'b00, q});
    r36 = stg_q[NSTG].mneg ? w36 + qd : w36 - qd;
    if (stg_q[NSTG].fault) begin
      res_w = stg_q[NSTG].weight;
    end else if (r36 > 36'sd2147483647) begin
      res_w = 32'h7FFF_FFFF;
    end else if (r36 < -36'sd2147483648) begin
      res_w = 32'h8000_0000;
    end else begin
      res_w = r36[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (vld_q[NSTG] && en) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[NSTG] && en) begin
      out_w_q <= res_w;
      out_f_q <= stg_q[NSTG].fault;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.weight_out = out_w_q;
  assign out_if.bias_fault = out_f_q;

  `ADAM_ASSERT_NEVER(a_req_in_clear, in_if.valid && in_if.ready && clr_busy,
                     "request accepted during clear")
  `ADAM_ASSERT(a_out_from_pipe, $rose(out_valid_q) |-> $past(vld_q[NSTG]),
               "result without pipeline item")
  `ADAM_ASSERT(a_pow_range, (p1_q <= POW_ONE) && (p2_q <= POW_ONE),
               "decay power above one")

endmodule

[design/adam_moment_unit.sv]
// moment stores with read, update and write back of first and second moments
`include "adam_optimizer_update_assert.svh"
module adam_moment_unit import adam_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    accept_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    clr_busy_o,
  output moment_t mo_o
);

  logic [DATA_W-1:0] m_mem [0:NUM_PARAMS-1];
  logic [DATA_W-1:0] v_mem [0:NUM_PARAMS-1];

  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic              a_vld_q;
  item_t             a_item_q;
  logic              a_inside_q;
  logic [31:0]       a_g2_q;
  logic [DATA_W-1:0] m_rd_q, v_rd_q;

  logic              fwd_vld_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [DATA_W-1:0] fwd_m_q, fwd_v_q;

  logic [31:0]        gmag;
  logic [63:0]        gsq;
  logic [39:0]        g2w;
  logic [31:0]        g2_d;
  logic [ADDR_W-1:0]  in_addr, a_addr, wr_addr;
  logic               fwd_hit, wr_en;
  logic signed [31:0] m_old, g_s;
  logic [31:0]        v_old;
  logic signed [50:0] pa, pb, mx, ms;
  logic [49:0]        vx, vs;
  logic [31:0]        m_new, v_new, wr_m, wr_v;

  // squared gradient, rounded to q8.24
  always_comb begin
    g_s  = signed'(item_i.grad);
    gmag = g_s[31] ? 32'(-g_s) : 32'(g_s);
    gsq  = 64'(gmag) * 64'(gmag);
    g2w  = 40'((gsq + 64'd8388608) >> 24);
    g2_d = (|g2w[39:32]) ? 32'hFFFF_FFFF : g2w[31:0];
  end

  assign in_addr = ADDR_W'(item_i.idx);
  assign a_addr  = ADDR_W'(a_item_q.idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(NUM_PARAMS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q   <= accept_i;
      fwd_vld_q <= a_vld_q && a_inside_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q   <= item_i;
      a_inside_q <= 32'(item_i.idx) < 32'(NUM_PARAMS);
      a_g2_q     <= g2_d;
      fwd_addr_q <= a_addr;
      fwd_m_q    <= m_new;
      fwd_v_q    <= v_new;
    end
  end

  // a write at the same edge as the read is forwarded
  always_comb begin
    fwd_hit = fwd_vld_q && (fwd_addr_q == a_addr);
    if (!a_inside_q) begin
      m_old = '0;
      v_old = '0;
    end else if (fwd_hit) begin
      m_old = signed'(fwd_m_q);
      v_old = fwd_v_q;
    end else begin
      m_old = signed'(m_rd_q);
      v_old = v_rd_q;
    end
  end

  always_comb begin
    pa = $signed(51'(cfg_i.first_decay)) * 51'(m_old);
    pb = $signed(51'(POW_ONE - 17'(cfg_i.first_decay)))
         * 51'(signed'(a_item_q.grad));
    mx = pa + pb + 51'sd32768;
    ms = mx >>> 16;
    if (ms > 51'sd2147483647) begin
      m_new = 32'h7FFF_FFFF;
    end else if (ms < -51'sd2147483648) begin
      m_new = 32'h8000_0000;
    end else begin
      m_new = ms[31:0];
    end
    vx = 50'(cfg_i.second_decay) * 50'(v_old)
         + 50'(POW_ONE - 17'(cfg_i.second_decay)) * 50'(a_g2_q) + 50'd32768;
    vs = vx >> 16;
    v_new = (|vs[49:32]) ? 32'hFFFF_FFFF : vs[31:0];
  end

  always_comb begin
    wr_en   = clr_busy_q || (en_i && a_vld_q && a_inside_q);
    wr_addr = clr_busy_q ? clr_addr_q : a_addr;
    wr_m    = clr_busy_q ? '0 : m_new;
    wr_v    = clr_busy_q ? '0 : v_new;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      m_mem[wr_addr] <= wr_m;
      v_mem[wr_addr] <= wr_v;
    end
    if (accept_i) begin
      m_rd_q <= m_mem[in_addr];
      v_rd_q <= v_mem[in_addr];
    end
  end

  assign clr_busy_o  = clr_busy_q;
  assign mo_o.valid  = a_vld_q;
  assign mo_o.item   = a_item_q;
  assign mo_o.m      = m_new;
  assign mo_o.v      = v_new;

  `ADAM_ASSERT(a_clear_once, !clr_busy_q |=> !clr_busy_q, "clear pass restarted")
  `ADAM_ASSERT_NEVER(a_acc_in_clear, accept_i && (clr_busy_q || !en_i),
                     "request accepted during clear or stall")

endmodule
